// ===== hw/rtl/chtm_pkg.sv =====
// Shared types and codes for the calorimeter hit-time merger.
package chtm_pkg;

    // Operation codes carried in func
    localparam logic [1:0] FUNC_DEPOSIT = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_MERGED   = 3'd0;
    localparam logic [2:0] ST_NEW_HIT  = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_IGNORED  = 3'd3;
    localparam logic [2:0] ST_READ     = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    localparam int TIME_W   = 20;
    localparam int ENERGY_W = 24;
    localparam int DEN_W    = ENERGY_W + 1;
    localparam int PROD_W   = TIME_W + ENERGY_W;
    localparam int NUM_W    = TIME_W + DEN_W + 1;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

    // Register map
    localparam logic REG_MERGE_WINDOW     = 1'b0;
    localparam logic REG_ENERGY_THRESHOLD = 1'b1;
    localparam logic [TIME_W-1:0]   MERGE_WINDOW_RST     = 20'd600;
    localparam logic [ENERGY_W-1:0] ENERGY_THRESHOLD_RST = 24'd30000;

    typedef struct packed {
        logic [TIME_W-1:0]   merge_window;
        logic [ENERGY_W-1:0] energy_threshold;
    } cfg_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [TIME_W-1:0]   read_time;
        logic [ENERGY_W-1:0] read_energy;
        logic                slot_used;
        logic                above_threshold;
        logic [7:0]          hit_count;
    } res_t;

endpackage

// ===== hw/rtl/chtm_req_if.sv =====
// Request and response channel interfaces.
interface chtm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [5:0]  row;
    logic [5:0]  column;
    logic [19:0] time_in;
    logic [19:0] time_out;
    logic [23:0] energy;
    logic [6:0]  hit_slot;

    modport source (output valid, func, row, column, time_in, time_out, energy, hit_slot,
                    input ready);
    modport sink (input valid, func, row, column, time_in, time_out, energy, hit_slot,
                  output ready);
endinterface

interface chtm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [19:0] read_time;
    logic [23:0] read_energy;
    logic        slot_used;
    logic        above_threshold;
    logic [7:0]  hit_count;

    modport source (output valid, status, read_time, read_energy, slot_used,
                    above_threshold, hit_count, input ready);
    modport sink (input valid, status, read_time, read_energy, slot_used,
                  above_threshold, hit_count, output ready);
endinterface

// ===== hw/rtl/chtm_apb_regs.sv =====
// APB configuration registers: merge window and energy threshold.
module chtm_apb_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output chtm_pkg::cfg_t cfg
);
    import chtm_pkg::*;

    logic [TIME_W-1:0]   merge_window_reg;
    logic [ENERGY_W-1:0] energy_threshold_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_window_reg     <= MERGE_WINDOW_RST;
            energy_threshold_reg <= ENERGY_THRESHOLD_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_MERGE_WINDOW)
                merge_window_reg <= pwdata[TIME_W-1:0];
            else
                energy_threshold_reg <= pwdata[ENERGY_W-1:0];
        end
    end

    // read back
    always_comb
    begin
        if (paddr[2] == REG_MERGE_WINDOW)
            prdata = 32'(merge_window_reg);
        else
            prdata = 32'(energy_threshold_reg);
    end

    assign cfg.merge_window     = merge_window_reg;
    assign cfg.energy_threshold = energy_threshold_reg;
endmodule

// ===== hw/rtl/chtm_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the weighted-mean time.
module chtm_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [chtm_pkg::NUM_W-1:0]    num,
    input  logic [chtm_pkg::DEN_W-1:0]    den,
    output logic                          done,
    output logic [chtm_pkg::TIME_W-1:0]   quotient
);
    import chtm_pkg::*;

    localparam int CNT_W = $clog2(TIME_W + 1);

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [TIME_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0]  den_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic              take;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, q_reg[TIME_W-1]};
    assign take  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // quotient fits TIME_W bits, so the upper part is below the divisor
            rem_next  = num[TIME_W+DEN_W-1:TIME_W];
            q_next    = num[TIME_W-1:0];
            cnt_next  = CNT_W'(TIME_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = take ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            q_next   = {q_reg[TIME_W-2:0], take};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
            den_reg <= den;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

// ===== hw/rtl/calorimeter_hit_time_merger.sv =====
// Top level: per-block hit lists in on-chip memories with scan, merge and readout.
//
// Usage: requests arrive on hit_in (valid/ready), one response per request
// leaves on hit_out (valid/ready). Registers are written over the APB port.
// func 0 deposits energy into a block's hit list, func 1 reads one slot,
// func 2 clears a block.
// One request is processed at a time. A deposit reads the block's hit
// count, then scans the list one slot per cycle from the hit memory's
// single read port; a merge then passes the multiply and add states and
// the bit-serial divider before the merged hit is written back.
// The response sits in an output register, so the next request is taken
// while it waits; a stalled receiver holds the response and, once the next
// result is ready, holds the request pipeline too.
// Reset: the hit-count memory is swept to zero, one block per cycle;
// no request is taken until the sweep ends. Configuration writes are
// taken at all times.
module calorimeter_hit_time_merger #(
    parameter int NUM_ROWS       = 64,
    parameter int NUM_COLUMNS    = 64,
    parameter int HITS_PER_BLOCK = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    chtm_req_if.sink    hit_in,
    chtm_rsp_if.source  hit_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import chtm_pkg::*;

    localparam int NB  = NUM_ROWS * NUM_COLUMNS;
    localparam int BW  = (NB > 1) ? $clog2(NB) : 1;
    localparam int CW  = $clog2(HITS_PER_BLOCK + 1);
    localparam int HD  = NB * HITS_PER_BLOCK;
    localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
    localparam int HW  = TIME_W + ENERGY_W;

    typedef enum logic [8:0] {
        S_INIT = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_CNT  = 9'b000000100,
        S_SCAN = 9'b000001000,
        S_RDW  = 9'b000010000,
        S_MUL  = 9'b000100000,
        S_SUM  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_RESP = 9'b100000000
    } state_t;

    cfg_t cfg;

    chtm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // memories
    logic [CW-1:0] cnt_mem [NB];
    logic [HW-1:0] hit_mem [HD];

    logic          cnt_we, cnt_re;
    logic [BW-1:0] cnt_waddr, cnt_raddr;
    logic [CW-1:0] cnt_wdata, cnt_rdata_reg;
    logic          hit_we, hit_re;
    logic [HAW-1:0] hit_waddr, hit_raddr;
    logic [HW-1:0] hit_wdata, hit_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re)
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hit_we)
            hit_mem[hit_waddr] <= hit_wdata;
        if (hit_re)
            hit_rdata_reg <= hit_mem[hit_raddr];
    end

    // control state
    state_t           state_reg, state_next;
    logic [BW:0]      init_reg, init_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg, out_next;
    res_t             res_reg, res_next;
    logic [CW-1:0]    issue_reg, issue_next;
    logic             chk_v_reg, chk_v_next;
    logic [CW-1:0]    chk_idx_reg, chk_idx_next;

    // request payload and working registers
    logic [1:0]          func_reg, func_next;
    logic                blk_ok_reg, blk_ok_next;
    logic [BW-1:0]       blk_reg, blk_next;
    logic [HAW-1:0]      base_reg, base_next;
    logic [TIME_W-1:0]   t_reg, t_next;
    logic [ENERGY_W-1:0] e_reg, e_next;
    logic [8:0]          slot_reg, slot_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [TIME_W-1:0]   hit_t_reg, hit_t_next;
    logic [ENERGY_W-1:0] hit_e_reg, hit_e_next;
    logic [CW-1:0]       match_reg, match_next;
    logic [PROD_W-1:0]   prod_a_reg, prod_b_reg;
    logic [DEN_W-1:0]    den_reg;

    logic [HAW-1:0]      base_now;
    logic [CW-1:0]       cnt_now;
    logic [TIME_W-1:0]   chk_t;
    logic [ENERGY_W-1:0] chk_e;
    logic [TIME_W-1:0]   diff;
    logic                match_now;
    logic                div_start, div_done;
    logic [NUM_W-1:0]    div_num;
    logic [TIME_W-1:0]   div_q;
    logic [7:0]          cnt8_now, cnt8_inc, cnt8_reg;

    assign base_now = HAW'(32'(blk_reg) * 32'(HITS_PER_BLOCK));
    assign cnt_now  = blk_ok_reg ? cnt_rdata_reg : '0;
    assign chk_t    = hit_rdata_reg[HW-1:ENERGY_W];
    assign chk_e    = hit_rdata_reg[ENERGY_W-1:0];
    assign diff     = (chk_t > t_reg) ? (chk_t - t_reg) : (t_reg - chk_t);
    assign match_now = chk_v_reg && (diff < cfg.merge_window);
    assign cnt8_now = 8'(cnt_now);
    assign cnt8_inc = 8'(count_reg + 1'b1);
    assign cnt8_reg = 8'(count_reg);

    assign div_num = NUM_W'(prod_a_reg) + NUM_W'(prod_b_reg) + NUM_W'(den_reg >> 1);

    chtm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign hit_in.ready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        res_next       = res_reg;
        issue_next     = issue_reg;
        chk_v_next     = 1'b0;
        chk_idx_next   = chk_idx_reg;
        func_next      = func_reg;
        blk_ok_next    = blk_ok_reg;
        blk_next       = blk_reg;
        base_next      = base_reg;
        t_next         = t_reg;
        e_next         = e_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        hit_t_next     = hit_t_reg;
        hit_e_next     = hit_e_reg;
        match_next     = match_reg;
        cnt_we         = 1'b0;
        cnt_waddr      = blk_reg;
        cnt_wdata      = '0;
        cnt_re         = 1'b0;
        cnt_raddr      = blk_reg;
        hit_we         = 1'b0;
        hit_waddr      = base_reg + HAW'(count_reg);
        hit_wdata      = {t_reg, e_reg};
        hit_re         = 1'b0;
        hit_raddr      = base_reg + HAW'(issue_reg);
        div_start      = 1'b0;

        if (out_valid_reg && hit_out.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            // zero the hit-count memory after reset
            S_INIT:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = init_reg[BW-1:0];
                init_next = init_reg + 1'b1;
                if (init_reg == (BW+1)'(NB - 1))
                    state_next = S_IDLE;
            end

            // take a request, look up the block's count
            S_IDLE:
            begin
                if (hit_in.valid)
                begin
                    func_next   = hit_in.func;
                    blk_ok_next = (9'(hit_in.row) < 9'(NUM_ROWS)) &&
                                  (9'(hit_in.column) < 9'(NUM_COLUMNS));
                    blk_next    = blk_ok_next ?
                                  BW'(17'(hit_in.row) * 17'(NUM_COLUMNS) + 17'(hit_in.column)) :
                                  '0;
                    t_next      = TIME_W'((21'(hit_in.time_in) + 21'(hit_in.time_out)) >> 1);
                    e_next      = hit_in.energy;
                    slot_next   = 9'(hit_in.hit_slot);
                    cnt_re      = 1'b1;
                    cnt_raddr   = blk_next;
                    state_next  = S_CNT;
                end
            end

            // dispatch on the operation
            S_CNT:
            begin
                base_next  = base_now;
                count_next = cnt_now;
                issue_next = '0;
                res_next   = '{status: ST_IGNORED, read_time: '0, read_energy: '0,
                               slot_used: 1'b0, above_threshold: 1'b0, hit_count: cnt8_now};
                state_next = S_RESP;
                case (func_reg)
                    FUNC_DEPOSIT:
                    begin
                        if (blk_ok_reg && (e_reg != '0))
                            state_next = S_SCAN;
                    end
                    FUNC_READ:
                    begin
                        res_next.status = ST_READ;
                        if (slot_reg < 9'(cnt_now))
                        begin
                            hit_re     = 1'b1;
                            hit_raddr  = base_now + HAW'(slot_reg);
                            state_next = S_RDW;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        res_next.status    = ST_CLEARED;
                        res_next.hit_count = '0;
                        cnt_we             = blk_ok_reg;
                    end
                    default:
                    begin
                        res_next.status = ST_IGNORED;
                    end
                endcase
            end

            // pipelined scan: issue one slot read per cycle, check the previous one
            S_SCAN:
            begin
                if (match_now)
                begin
                    hit_t_next = chk_t;
                    hit_e_next = chk_e;
                    match_next = chk_idx_reg;
                    state_next = S_MUL;
                end
                else if (issue_reg != count_reg)
                begin
                    hit_re       = 1'b1;
                    issue_next   = issue_reg + 1'b1;
                    chk_v_next   = 1'b1;
                    chk_idx_next = issue_reg;
                end
                else if (!chk_v_reg)
                begin
                    state_next = S_RESP;
                    if (count_reg < CW'(HITS_PER_BLOCK))
                    begin
                        hit_we             = 1'b1;
                        cnt_we             = 1'b1;
                        cnt_wdata          = count_reg + 1'b1;
                        res_next.status    = ST_NEW_HIT;
                        res_next.hit_count = cnt8_inc;
                    end
                    else
                    begin
                        res_next.status = ST_OVERFLOW;
                    end
                end
            end

            // read data returns
            S_RDW:
            begin
                res_next.read_time       = chk_t;
                res_next.read_energy     = chk_e;
                res_next.slot_used       = 1'b1;
                res_next.above_threshold = (chk_e >= cfg.energy_threshold);
                state_next               = S_RESP;
            end

            // products and combined energy
            S_MUL:
            begin
                state_next = S_SUM;
            end

            S_SUM:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end

            // weighted-mean time written back with the saturated energy
            S_DIV:
            begin
                if (div_done)
                begin
                    hit_we    = 1'b1;
                    hit_waddr = base_reg + HAW'(match_reg);
                    hit_wdata = {div_q, (den_reg > DEN_W'(ENERGY_MAX)) ?
                                        ENERGY_MAX : den_reg[ENERGY_W-1:0]};
                    res_next.status    = ST_MERGED;
                    res_next.hit_count = cnt8_reg;
                    state_next         = S_RESP;
                end
            end

            // hand the result to the output register
            S_RESP:
            begin
                if (!out_valid_reg || hit_out.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            out_valid_reg <= 1'b0;
            chk_v_reg     <= 1'b0;
            issue_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
            chk_v_reg     <= chk_v_next;
            issue_reg     <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        res_reg     <= res_next;
        chk_idx_reg <= chk_idx_next;
        func_reg    <= func_next;
        blk_ok_reg  <= blk_ok_next;
        blk_reg     <= blk_next;
        base_reg    <= base_next;
        t_reg       <= t_next;
        e_reg       <= e_next;
        slot_reg    <= slot_next;
        count_reg   <= count_next;
        hit_t_reg   <= hit_t_next;
        hit_e_reg   <= hit_e_next;
        match_reg   <= match_next;
        prod_a_reg  <= hit_t_reg * hit_e_reg;
        prod_b_reg  <= t_reg * e_reg;
        den_reg     <= DEN_W'(hit_e_reg) + DEN_W'(e_reg);
    end

    assign hit_out.valid           = out_valid_reg;
    assign hit_out.status          = out_reg.status;
    assign hit_out.read_time       = out_reg.read_time;
    assign hit_out.read_energy     = out_reg.read_energy;
    assign hit_out.slot_used       = out_reg.slot_used;
    assign hit_out.above_threshold = out_reg.above_threshold;
    assign hit_out.hit_count       = out_reg.hit_count;
endmodule

// ===== hw/rtl/chtm_checker.sv =====
// Port-level checks for the hit-time merger and their bind.
module chtm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [23:0] read_energy,
    input logic        slot_used,
    input logic        above_threshold
);
    import chtm_pkg::*;

    // a held response stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response dropped while stalled");

    // one request at a time: ready drops after an accepted request
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // only reads carry slot data
    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_READ) |-> (read_energy == '0) && !slot_used)
        else $error("slot data on a non-read response");

    // threshold flag only for a used slot
    a_above_used: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && above_threshold |-> slot_used)
        else $error("threshold flag on an unused slot");
endmodule

bind calorimeter_hit_time_merger chtm_checker u_chtm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (hit_in.valid),
    .in_ready        (hit_in.ready),
    .out_valid       (hit_out.valid),
    .out_ready       (hit_out.ready),
    .status          (hit_out.status),
    .read_energy     (hit_out.read_energy),
    .slot_used       (hit_out.slot_used),
    .above_threshold (hit_out.above_threshold)
);
